// ===== rtl/locale_hash_probe_lookup_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the hash table lookup block
// Implication checks sampled on the rising clock edge and held off during
// reset. Building with NO_ASSERTIONS defined leaves them empty.
// ----------------------------------------------------------------------------
`ifndef LOCALE_HASH_PROBE_LOOKUP_ASSERT_SVH
`define LOCALE_HASH_PROBE_LOOKUP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define LHPL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LHPL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define LHPL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LHPL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/lhpl_pkg.sv =====
// ----------------------------------------------------------------------------
// Hash table lookup package
// Field widths, action and register codes, slot entry layout and the
// microcode program of the lookup sequencer.
// ----------------------------------------------------------------------------
package lhpl_pkg;

	localparam int ACT_W      = 2;
	localparam int SLOT_W     = 12;
	localparam int HASH_W     = 32;
	localparam int LOC_W      = 16;
	localparam int BLK_W      = 32;
	localparam int SIZE_W     = 13;
	localparam int BCNT_W     = 21;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 21;

	localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FIND   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

	localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 13'd4096;
	localparam logic [BLK_W-1:0]  EMPTY_BLOCK    = '1;

	// Remainder unit: quotient bits retired per cycle.
	localparam int DVD_W     = 32;
	localparam int DIV_BITS  = 4;
	localparam int DIV_ITERS = DVD_W / DIV_BITS;
	localparam int DIV_IT_W  = $clog2(DIV_ITERS);

	typedef struct packed {
		logic [HASH_W-1:0] hash_a;
		logic [HASH_W-1:0] hash_b;
		logic [LOC_W-1:0]  locale;
		logic [BLK_W-1:0]  block;
	} slot_entry_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

	// Program steps.
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] S_CLEAR    = 4'd0;
	localparam logic [PC_W-1:0] S_IDLE     = 4'd1;
	localparam logic [PC_W-1:0] S_DISPATCH = 4'd2;
	localparam logic [PC_W-1:0] S_CHECK    = 4'd3;
	localparam logic [PC_W-1:0] S_DIV      = 4'd4;
	localparam logic [PC_W-1:0] S_PSTART   = 4'd5;
	localparam logic [PC_W-1:0] S_PROBE    = 4'd6;
	localparam logic [PC_W-1:0] S_WRITE    = 4'd7;
	localparam logic [PC_W-1:0] S_RESULT   = 4'd8;

	// Jump conditions.
	localparam int COND_W = 3;
	localparam logic [COND_W-1:0] C_ALWAYS    = 3'd0;
	localparam logic [COND_W-1:0] C_CLR_LAST  = 3'd1;
	localparam logic [COND_W-1:0] C_IN_FIRE   = 3'd2;
	localparam logic [COND_W-1:0] C_ACT_WRITE = 3'd3;
	localparam logic [COND_W-1:0] C_ACT_PROBE = 3'd4;
	localparam logic [COND_W-1:0] C_DIV_LAST  = 3'd5;
	localparam logic [COND_W-1:0] C_PROBE_END = 3'd6;
	localparam logic [COND_W-1:0] C_OUT_FREE  = 3'd7;

	typedef struct packed {
		logic clr_last;
		logic in_fire;
		logic act_write;
		logic act_probe;
		logic div_last;
		logic probe_end;
		logic out_free;
	} useq_flags_t;

	typedef struct packed {
		logic              in_ready;
		logic              clr_wr;
		logic              mem_wr;
		logic              res_clr;
		logic              div_load;
		logic              div_step;
		logic              p_init;
		logic              p_step;
		logic              out_load;
		logic [COND_W-1:0] cond;
		logic [PC_W-1:0]   jt;
		logic [PC_W-1:0]   jf;
	} useq_word_t;

	// One control word per step; next step is jt when the condition holds, else jf.
	function automatic useq_word_t useq_rom(input logic [PC_W-1:0] pc);
		useq_word_t w;
		w = '0;
		w.cond = C_ALWAYS;
		w.jt = S_IDLE;
		w.jf = S_IDLE;
		case (pc)
			S_CLEAR: begin
				w.clr_wr = 1'b1;
				w.cond = C_CLR_LAST;
				w.jt = S_IDLE;
				w.jf = S_CLEAR;
			end
			S_IDLE: begin
				w.in_ready = 1'b1;
				w.cond = C_IN_FIRE;
				w.jt = S_DISPATCH;
				w.jf = S_IDLE;
			end
			S_DISPATCH: begin
				w.res_clr = 1'b1;
				w.div_load = 1'b1;
				w.cond = C_ACT_WRITE;
				w.jt = S_WRITE;
				w.jf = S_CHECK;
			end
			S_CHECK: begin
				w.cond = C_ACT_PROBE;
				w.jt = S_DIV;
				w.jf = S_RESULT;
			end
			S_DIV: begin
				w.div_step = 1'b1;
				w.cond = C_DIV_LAST;
				w.jt = S_PSTART;
				w.jf = S_DIV;
			end
			S_PSTART: begin
				w.p_init = 1'b1;
				w.cond = C_ALWAYS;
				w.jt = S_PROBE;
				w.jf = S_PROBE;
			end
			S_PROBE: begin
				w.p_step = 1'b1;
				w.cond = C_PROBE_END;
				w.jt = S_RESULT;
				w.jf = S_PROBE;
			end
			S_WRITE: begin
				w.mem_wr = 1'b1;
				w.cond = C_ALWAYS;
				w.jt = S_RESULT;
				w.jf = S_RESULT;
			end
			S_RESULT: begin
				w.out_load = 1'b1;
				w.cond = C_OUT_FREE;
				w.jt = S_IDLE;
				w.jf = S_RESULT;
			end
			default: begin
				w.cond = C_ALWAYS;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/lhpl_in_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one table operation per transaction.
// ----------------------------------------------------------------------------
interface lhpl_in_if import lhpl_pkg::*;;

	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [SLOT_W-1:0] slot;
	logic              from_valid;
	logic [HASH_W-1:0] name_hash_a;
	logic [HASH_W-1:0] name_hash_b;
	logic [HASH_W-1:0] start_hash;
	logic [LOC_W-1:0]  want_locale;
	logic [LOC_W-1:0]  entry_locale;
	logic [BLK_W-1:0]  entry_block;

	modport source (
		output valid, action, slot, from_valid, name_hash_a, name_hash_b,
		       start_hash, want_locale, entry_locale, entry_block,
		input  ready
	);

	modport sink (
		input  valid, action, slot, from_valid, name_hash_a, name_hash_b,
		       start_hash, want_locale, entry_locale, entry_block,
		output ready
	);

endinterface

// ===== rtl/lhpl_out_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one lookup result per transaction.
// ----------------------------------------------------------------------------
interface lhpl_out_if import lhpl_pkg::*;;

	logic              valid;
	logic              ready;
	logic              found;
	logic [SLOT_W-1:0] found_slot;
	logic              locale_exact;

	modport source (
		output valid, found, found_slot, locale_exact,
		input  ready
	);

	modport sink (
		input  valid, found, found_slot, locale_exact,
		output ready
	);

endinterface

// ===== rtl/lhpl_rem.sv =====
// ----------------------------------------------------------------------------
// Probe start remainder unit
// Restoring remainder of a 32-bit dividend by the table size, retiring
// DIV_BITS dividend bits per cycle while stepped, most significant first.
// ----------------------------------------------------------------------------
module lhpl_rem import lhpl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  div_ctrl_t         ctrl,
	input  logic [DVD_W-1:0]  dividend,
	input  logic [SIZE_W-1:0] divisor,
	output logic [SIZE_W-1:0] rem,
	output logic              last
);

	logic [DVD_W-1:0]    dvd_q;
	logic [SIZE_W-1:0]   rem_q;
	logic [DIV_IT_W-1:0] it_q;
	logic [SIZE_W-1:0]   rem_nx;

	// The partial remainder stays below the divisor, so each trial value is
	// below twice the divisor and one conditional subtract suffices.
	always_comb begin
		logic [SIZE_W:0]   t;
		logic [SIZE_W-1:0] r;
		r = rem_q;
		for (int i = 0; i < DIV_BITS; i++) begin
			t = {r, dvd_q[DVD_W-1-i]};
			if (t >= {1'b0, divisor}) begin
				t = t - {1'b0, divisor};
			end
			r = t[SIZE_W-1:0];
		end
		rem_nx = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_q <= '0;
		end else if (ctrl.load) begin
			it_q <= '0;
		end else if (ctrl.step) begin
			it_q <= it_q + DIV_IT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (ctrl.step) begin
			dvd_q <= dvd_q << DIV_BITS;
			rem_q <= rem_nx;
		end
	end

	assign rem  = rem_q;
	assign last = (it_q == DIV_IT_W'(DIV_ITERS - 1));

endmodule

// ===== rtl/lhpl_useq.sv =====
// ----------------------------------------------------------------------------
// Lookup sequencer
// Step counter over the microcode program with a two-way conditional jump
// on every step.
// ----------------------------------------------------------------------------
module lhpl_useq import lhpl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  useq_flags_t flags,
	output useq_word_t  word
);

	logic [PC_W-1:0] pc_q;
	logic            cond_true;

	assign word = useq_rom(pc_q);

	always_comb begin
		case (word.cond)
			C_ALWAYS:    cond_true = 1'b1;
			C_CLR_LAST:  cond_true = flags.clr_last;
			C_IN_FIRE:   cond_true = flags.in_fire;
			C_ACT_WRITE: cond_true = flags.act_write;
			C_ACT_PROBE: cond_true = flags.act_probe;
			C_DIV_LAST:  cond_true = flags.div_last;
			C_PROBE_END: cond_true = flags.probe_end;
			C_OUT_FREE:  cond_true = flags.out_free;
			default:     cond_true = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_CLEAR;
		end else begin
			pc_q <= cond_true ? word.jt : word.jf;
		end
	end

endmodule

// ===== rtl/locale_hash_probe_lookup.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash table lookup with locale preference
// Slot table of name hashes, locale and block index, loaded by write
// transactions and searched by locale lookup and find-next transactions.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake     | Contents
//  --------+-----------+---------------+------------------------------------------
//  req     | in        | valid/ready   | action, slot, hashes, locales, block index
//  rsp     | out       | valid/ready   | found, found_slot, locale_exact
//  cfg     | in        | cfg_we only   | cfg_index selects table_size/block_count
//
//  A write passes through the dispatch, write and result steps; an unused action
//  code through dispatch, check and result. A lookup or find-next passes through
//  dispatch, check, the remainder unit (4 quotient bits per cycle), probe start, a
//  probe step per slot read from the slot memory, and result. After reset a
//  clearing pass marks every slot empty; req.ready stays low until it is done.
//  One transaction is in work at a time; a finished result waits in the output
//  register while the next is accepted.
//
// ----------------------------------------------------------------------------
`include "locale_hash_probe_lookup_assert.svh"

module locale_hash_probe_lookup import lhpl_pkg::*; #(
	parameter int MAX_SLOTS      = 4096,
	parameter int LOCALE_NEUTRAL = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	lhpl_in_if.sink               req,
	lhpl_out_if.source            rsp
);

	localparam int                AW          = $clog2(MAX_SLOTS);
	localparam logic [31:0]       MAX_SLOTS_W = 32'(MAX_SLOTS);
	localparam logic [AW-1:0]     CLR_LAST    = AW'(MAX_SLOTS - 1);
	localparam logic [LOC_W-1:0]  NEUTRAL     = LOC_W'(LOCALE_NEUTRAL);
	// Effective size right after reset: the reset table size, capped by the
	// memory depth.
	localparam logic [SIZE_W-1:0] EFF_RST     = (MAX_SLOTS < int'(TABLE_SIZE_RST)) ?
	                                            SIZE_W'(MAX_SLOTS) : TABLE_SIZE_RST;

	// Next probe index, wrapping at the effective table size.
	function automatic logic [SIZE_W-1:0] wrap_inc(input logic [SIZE_W-1:0] x,
	                                               input logic [SIZE_W-1:0] size);
		logic [SIZE_W-1:0] y;
		y = x + SIZE_W'(1);
		return (y == size) ? '0 : y;
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic [SIZE_W-1:0] table_size_q;
	logic [BCNT_W-1:0] block_count_q;
	logic [SIZE_W-1:0] eff_size_q;
	logic [SIZE_W-1:0] eff_size_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q  <= TABLE_SIZE_RST;
			block_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TABLE_SIZE:  table_size_q  <= cfg_data[SIZE_W-1:0];
				REG_BLOCK_COUNT: block_count_q <= cfg_data[BCNT_W-1:0];
				default:         block_count_q <= block_count_q;
			endcase
		end
	end

	// A size of zero behaves as one, and a size above the memory depth is capped.
	// The result is registered so the remainder unit and probe wrap see a settled
	// value; the user must change configuration only while idle (not enforced).
	always_comb begin
		if (table_size_q == '0) begin
			eff_size_c = SIZE_W'(1);
		end else if (32'(table_size_q) > MAX_SLOTS_W) begin
			eff_size_c = SIZE_W'(MAX_SLOTS);
		end else begin
			eff_size_c = table_size_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_size_q <= EFF_RST;
		end else begin
			eff_size_q <= eff_size_c;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	useq_flags_t flags;
	useq_word_t  uw;

	lhpl_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.word   (uw)
	);

	logic in_fire;
	assign req.ready = uw.in_ready;
	assign in_fire   = req.valid && uw.in_ready;

	// ------------------------------------------------------------------
	// Captured request fields.
	// ------------------------------------------------------------------
	logic [ACT_W-1:0]  act_q;
	logic [SLOT_W-1:0] slot_q;
	logic              from_q;
	logic [HASH_W-1:0] ha_q;
	logic [HASH_W-1:0] hb_q;
	logic [HASH_W-1:0] start_q;
	logic [LOC_W-1:0]  want_q;
	logic [LOC_W-1:0]  eloc_q;
	logic [BLK_W-1:0]  eblk_q;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			act_q   <= req.action;
			slot_q  <= req.slot;
			from_q  <= req.from_valid;
			ha_q    <= req.name_hash_a;
			hb_q    <= req.name_hash_b;
			start_q <= req.start_hash;
			want_q  <= req.want_locale;
			eloc_q  <= req.entry_locale;
			eblk_q  <= req.entry_block;
		end
	end

	logic is_find;
	assign is_find = (act_q == ACT_FIND);

	// ------------------------------------------------------------------
	// Probe start: hash modulo size, or the slot after the from slot.
	// ------------------------------------------------------------------
	div_ctrl_t         div_ctrl;
	logic [DVD_W-1:0]  dividend;
	logic [SIZE_W-1:0] rem;
	logic              div_last;

	assign div_ctrl.load = uw.div_load;
	assign div_ctrl.step = uw.div_step;
	assign dividend = (is_find && from_q) ? DVD_W'({1'b0, slot_q} + SIZE_W'(1)) : start_q;

	lhpl_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (div_ctrl),
		.dividend (dividend),
		.divisor  (eff_size_q),
		.rem      (rem),
		.last     (div_last)
	);

	// ------------------------------------------------------------------
	// Slot memory. One write port, one registered read port. Every entry is
	// written to all ones during the clearing pass, which marks it empty.
	// ------------------------------------------------------------------
	slot_entry_t       slot_mem [MAX_SLOTS];
	slot_entry_t       rd_q;
	logic [AW-1:0]     clr_q;
	logic              slot_ok;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	slot_entry_t       mem_wd;
	logic [AW-1:0]     mem_ra;
	logic [SIZE_W-1:0] evl_q;
	logic [SIZE_W-1:0] nxt_q;
	logic [SIZE_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (uw.clr_wr) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// Writes to slots beyond the memory depth are dropped.
	assign slot_ok = (32'(slot_q) < MAX_SLOTS_W);
	assign mem_we  = uw.clr_wr || (uw.mem_wr && slot_ok);
	assign mem_wa  = uw.clr_wr ? clr_q : AW'(slot_q);
	assign mem_wd  = uw.clr_wr ? '1 : slot_entry_t'{hash_a: ha_q, hash_b: hb_q,
	                                               locale: eloc_q, block: eblk_q};
	// The first probe address comes from the remainder; afterwards the probe
	// reads one slot ahead of the one being evaluated.
	assign mem_ra  = uw.p_init ? AW'(rem) : AW'(nxt_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_wa] <= mem_wd;
		end
		rd_q <= slot_mem[mem_ra];
	end

	// ------------------------------------------------------------------
	// Probe evaluation. rd_q holds the entry of slot evl_q; cnt_q counts the
	// slots already examined in this lap.
	// ------------------------------------------------------------------
	logic              found_q;
	logic [SIZE_W-1:0] chosen_q;
	logic              exact_q;
	logic              hit;
	logic              exact;
	logic              stop;
	logic              take;
	logic              probe_end;

	assign hit   = (rd_q.block < BLK_W'(block_count_q)) &&
	               (rd_q.hash_a == ha_q) && (rd_q.hash_b == hb_q);
	assign exact = (rd_q.locale == want_q);

	// The chain ends after a full lap, on returning to the from slot of a
	// find-next, or at an empty slot; none of these slots is compared.
	assign stop = (cnt_q == eff_size_q) ||
	              (is_find && from_q && (evl_q == {1'b0, slot_q})) ||
	              (rd_q.block == EMPTY_BLOCK);

	// A find-next takes the first hit. A lookup takes an exact-locale hit and
	// ends there; otherwise it keeps the first hit, replaced by any later
	// neutral-locale hit.
	assign take = !stop && hit &&
	              (is_find || exact || !found_q || (rd_q.locale == NEUTRAL));
	assign probe_end = stop || (hit && (is_find || exact));

	always_ff @(posedge clk) begin
		if (uw.p_init) begin
			evl_q <= rem;
			nxt_q <= wrap_inc(rem, eff_size_q);
			cnt_q <= '0;
		end else if (uw.p_step) begin
			evl_q <= nxt_q;
			nxt_q <= wrap_inc(nxt_q, eff_size_q);
			cnt_q <= cnt_q + SIZE_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (uw.res_clr) begin
			found_q  <= 1'b0;
			chosen_q <= '0;
			exact_q  <= 1'b0;
		end else if (uw.p_step && take) begin
			found_q  <= 1'b1;
			chosen_q <= evl_q;
			exact_q  <= exact;
		end
	end

	// ------------------------------------------------------------------
	// Output register. It holds a finished result until the sink takes it,
	// while the sequencer goes back to accept the next transaction.
	// ------------------------------------------------------------------
	logic              out_valid_q;
	logic              out_found_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic              out_exact_q;
	logic              out_free;
	logic              out_load;

	assign out_free = !out_valid_q || rsp.ready;
	assign out_load = uw.out_load && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_found_q <= found_q;
			out_slot_q  <= SLOT_W'(chosen_q);
			out_exact_q <= exact_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.found        = out_found_q;
	assign rsp.found_slot   = out_slot_q;
	assign rsp.locale_exact = out_exact_q;

	// ------------------------------------------------------------------
	// Sequencer conditions.
	// ------------------------------------------------------------------
	assign flags.clr_last  = (clr_q == CLR_LAST);
	assign flags.in_fire   = in_fire;
	assign flags.act_write = (act_q == ACT_WRITE);
	assign flags.act_probe = (act_q == ACT_LOOKUP) || (act_q == ACT_FIND);
	assign flags.div_last  = div_last;
	assign flags.probe_end = probe_end;
	assign flags.out_free  = out_free;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`LHPL_ASSERT_IMP(a_start_in_range, clk, arst_n, uw.p_init, rem < eff_size_q, "probe start outside table")
	`LHPL_ASSERT_IMP(a_probe_in_range, clk, arst_n, uw.p_step, (evl_q < eff_size_q) && (cnt_q <= eff_size_q), "probe index or lap count outside table")
	`LHPL_ASSERT_NXT(a_one_in_work, clk, arst_n, in_fire, !uw.in_ready, "second transaction accepted while one is in work")

endmodule
